>>> rtl/tkv_pkg.sv
// ----------------------------------------------------------------------------
// tkv_pkg
// Shared constants and types for the transactional key/value table.
// ----------------------------------------------------------------------------
package tkv_pkg;

   localparam int TKV_CAPACITY    = 16;
   localparam int TKV_KEY_WIDTH   = 32;
   localparam int TKV_VALUE_WIDTH = 32;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 40;

   localparam logic [2:0] OP_GET      = 3'd0;
   localparam logic [2:0] OP_INSERT   = 3'd1;
   localparam logic [2:0] OP_REMOVE   = 3'd2;
   localparam logic [2:0] OP_BEGIN    = 3'd3;
   localparam logic [2:0] OP_COMMIT   = 3'd4;
   localparam logic [2:0] OP_ROLLBACK = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   // entry update command, applied at the table address
   typedef struct packed {
      logic key_we;
      logic cval_we;
      logic pval_we;
      logic cv_set;
      logic cv_clr;
      logic pw_set;
      logic pw_clr;
      logic pd_clr;
      logic pd_copy_cv;
      logic marks_clr;
      logic commit_we;
   } tkv_wr_type;

   // entry marks at the table address
   typedef struct packed {
      logic used;
      logic cv;
      logic pw;
      logic pd;
   } tkv_ent_type;

endpackage

>>> rtl/tkv_table.sv
// ----------------------------------------------------------------------------
// tkv_table
// Entry storage: keys, committed and pending values, per-entry marks.
// ----------------------------------------------------------------------------
module tkv_table #(
   parameter int CAPACITY    = tkv_pkg::TKV_CAPACITY,
   parameter int KEY_WIDTH   = tkv_pkg::TKV_KEY_WIDTH,
   parameter int VALUE_WIDTH = tkv_pkg::TKV_VALUE_WIDTH,
   parameter int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [IDX_W-1:0]       addr,
   input  tkv_pkg::tkv_wr_type    wr,
   input  logic [KEY_WIDTH-1:0]   key_wdata,
   input  logic [VALUE_WIDTH-1:0] val_wdata,
   output logic [KEY_WIDTH-1:0]   rd_key,
   output logic [VALUE_WIDTH-1:0] rd_cval,
   output logic [VALUE_WIDTH-1:0] rd_pval,
   output tkv_pkg::tkv_ent_type   ent
);
   import tkv_pkg::*;

   logic [KEY_WIDTH-1:0]   key_mem  [CAPACITY];
   logic [VALUE_WIDTH-1:0] cval_mem [CAPACITY];
   logic [VALUE_WIDTH-1:0] pval_mem [CAPACITY];

   logic [CAPACITY-1:0] cv_ff, cv_in;
   logic [CAPACITY-1:0] pw_ff, pw_in;
   logic [CAPACITY-1:0] pd_ff, pd_in;

   assign rd_key  = key_mem[addr];
   assign rd_cval = cval_mem[addr];
   assign rd_pval = pval_mem[addr];

   assign ent.cv   = cv_ff[addr];
   assign ent.pw   = pw_ff[addr];
   assign ent.pd   = pd_ff[addr];
   assign ent.used = cv_ff[addr] | pw_ff[addr];

   always_ff @(posedge clock) begin
      if (wr.key_we) begin
         key_mem[addr] <= key_wdata;
      end
      if (wr.pval_we) begin
         pval_mem[addr] <= val_wdata;
      end
      if (wr.commit_we && pw_ff[addr]) begin
         cval_mem[addr] <= pval_mem[addr];
      end else if (wr.cval_we) begin
         cval_mem[addr] <= val_wdata;
      end
   end

   always_comb begin
      cv_in = cv_ff;
      pw_in = pw_ff;
      pd_in = pd_ff;
      if (wr.marks_clr) begin
         pw_in = '0;
         pd_in = '0;
      end
      if (wr.cv_clr) begin
         cv_in[addr] = 1'b0;
      end
      if (wr.pw_clr) begin
         pw_in[addr] = 1'b0;
      end
      if (wr.pd_clr) begin
         pd_in[addr] = 1'b0;
      end
      if (wr.pd_copy_cv) begin
         pd_in[addr] = cv_ff[addr];
      end
      if (wr.commit_we) begin
         if (pw_ff[addr]) begin
            cv_in[addr] = 1'b1;
         end else if (pd_ff[addr]) begin
            cv_in[addr] = 1'b0;
         end
      end
      if (wr.cv_set) begin
         cv_in[addr] = 1'b1;
      end
      if (wr.pw_set) begin
         pw_in[addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= '0;
         pw_ff <= '0;
         pd_ff <= '0;
      end else begin
         cv_ff <= cv_in;
         pw_ff <= pw_in;
         pd_ff <= pd_in;
      end
   end

endmodule

>>> rtl/transactional_key_value_table_core.sv
// ----------------------------------------------------------------------------
// transactional_key_value_table_core
// Bounded key/value table with begin/commit/rollback transactions.
//
//  channel  dir  transfer                 payload
//  req_*    in   tvalid & tready          opcode, lookup_key, write_value
//  rsp_*    out  tvalid & tready          read_value, status
//
// Get, insert, remove and a commit inside a transaction scan the table one
// entry per cycle through a single key compare, then act in S_ACT.
// Begin, rollback, a commit outside a transaction and other opcodes skip the scan.
// Synchronous reset clears all marks and the transaction flag; no clearing pass.
// req_tready is high only while idle. A stalled response holds the result
// stage; the next request may still be taken and finishes when rsp drains.
// ----------------------------------------------------------------------------
module transactional_key_value_table_core #(
   parameter int CAPACITY    = tkv_pkg::TKV_CAPACITY,
   parameter int KEY_WIDTH   = tkv_pkg::TKV_KEY_WIDTH,
   parameter int VALUE_WIDTH = tkv_pkg::TKV_VALUE_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // opcode[2:0], lookup_key[34:3], write_value[66:35], zero fill
   input  logic [tkv_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // read_value[31:0], status[33:32], zero fill
   output logic [tkv_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import tkv_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_ACT  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [2:0]             op_ff, op_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [31:0]            req_key, req_val;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] match_ff, match_in;
   logic [IDX_W-1:0] free_ff, free_in;
   logic             found_ff, found_in;
   logic             free_ok_ff, free_ok_in;
   logic             in_tx_ff, in_tx_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      read_ff, read_in;
   logic [1:0]       status_ff, status_in;

   logic [IDX_W-1:0]       addr;
   tkv_wr_type             wr;
   tkv_ent_type            ent;
   logic [KEY_WIDTH-1:0]   rd_key;
   logic [VALUE_WIDTH-1:0] rd_cval, rd_pval;
   logic [VALUE_WIDTH-1:0] hit_val;
   logic [31:0]            hit_val32;
   logic                   keyed, fire, accept;

   assign req_key = req_tdata[34:3];
   assign req_val = req_tdata[66:35];

   generate
      if (KEY_WIDTH <= 32) begin : g_key_narrow
         assign key_in = req_key[KEY_WIDTH-1:0];
      end else begin : g_key_wide
         assign key_in = {{(KEY_WIDTH-32){1'b0}}, req_key};
      end
      if (VALUE_WIDTH <= 32) begin : g_val_narrow
         assign val_in    = req_val[VALUE_WIDTH-1:0];
         assign hit_val32 = {{(32-VALUE_WIDTH){1'b0}}, hit_val};
      end else begin : g_val_wide
         assign val_in    = {{(VALUE_WIDTH-32){1'b0}}, req_val};
         assign hit_val32 = hit_val[31:0];
      end
   endgenerate

   assign op_in = req_tdata[2:0];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign keyed      = (op_ff == OP_GET) || (op_ff == OP_INSERT) || (op_ff == OP_REMOVE);
   assign fire       = (state_ff == S_ACT) && (!rsp_valid_ff || rsp_tready);
   assign addr       = (state_ff == S_SCAN) ? idx_ff : (found_ff ? match_ff : free_ff);
   assign hit_val    = ent.pw ? rd_pval : rd_cval;

   tkv_table #(
      .CAPACITY    (CAPACITY),
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .addr      (addr),
      .wr        (wr),
      .key_wdata (key_ff),
      .val_wdata (val_ff),
      .rd_key    (rd_key),
      .rd_cval   (rd_cval),
      .rd_pval   (rd_pval),
      .ent       (ent)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      match_in     = match_ff;
      free_in      = free_ff;
      found_in     = found_ff;
      free_ok_in   = free_ok_ff;
      in_tx_in     = in_tx_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      read_in      = read_ff;
      status_in    = status_ff;
      wr           = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in     = '0;
               found_in   = 1'b0;
               free_ok_in = 1'b0;
               if ((op_in == OP_GET) || (op_in == OP_INSERT) || (op_in == OP_REMOVE) ||
                   ((op_in == OP_COMMIT) && in_tx_ff)) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_ACT;
               end
            end
         end
         S_SCAN: begin
            if (keyed) begin
               if (!found_ff && ent.used && (rd_key == key_ff)) begin
                  found_in = 1'b1;
                  match_in = idx_ff;
               end
               if (!free_ok_ff && !ent.used) begin
                  free_ok_in = 1'b1;
                  free_in    = idx_ff;
               end
            end else begin
               wr.commit_we = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) begin
               state_in = S_ACT;
            end
         end
         S_ACT: begin
            if (fire) begin
               rsp_valid_in = 1'b1;
               read_in      = '0;
               status_in    = ST_OK;
               state_in     = S_IDLE;
               case (op_ff)
                  OP_GET: begin
                     if (!found_ff) begin
                        status_in = ST_NOT_FOUND;
                     end else if (ent.pw || (!ent.pd && ent.cv)) begin
                        read_in = hit_val32;
                     end else begin
                        status_in = ST_NOT_FOUND;
                     end
                  end
                  OP_INSERT: begin
                     if (found_ff || free_ok_ff) begin
                        if (!found_ff) begin
                           wr.key_we = 1'b1;
                           wr.cv_clr = 1'b1;
                           wr.pd_clr = 1'b1;
                        end
                        if (in_tx_ff) begin
                           wr.pval_we = 1'b1;
                           wr.pw_set  = 1'b1;
                           wr.pd_clr  = 1'b1;
                        end else begin
                           wr.cval_we = 1'b1;
                           wr.cv_set  = 1'b1;
                        end
                     end else begin
                        status_in = ST_FULL;
                     end
                  end
                  OP_REMOVE: begin
                     if (found_ff) begin
                        if (in_tx_ff) begin
                           wr.pw_clr     = 1'b1;
                           wr.pd_copy_cv = 1'b1;
                        end else begin
                           wr.cv_clr = 1'b1;
                        end
                     end
                  end
                  OP_BEGIN: begin
                     in_tx_in = 1'b1;
                  end
                  OP_COMMIT: begin
                     if (in_tx_ff) begin
                        wr.marks_clr = 1'b1;
                        in_tx_in     = 1'b0;
                     end
                  end
                  OP_ROLLBACK: begin
                     wr.marks_clr = 1'b1;
                     in_tx_in     = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         found_ff     <= 1'b0;
         free_ok_ff   <= 1'b0;
         in_tx_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         found_ff     <= found_in;
         free_ok_ff   <= free_ok_in;
         in_tx_ff     <= in_tx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= op_in;
         key_ff <= key_in;
         val_ff <= val_in;
      end
      idx_ff    <= idx_in;
      match_ff  <= match_in;
      free_ff   <= free_in;
      read_ff   <= read_in;
      status_ff <= status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-34){1'b0}}, status_ff, read_ff};

endmodule
